[rtl/core/oir_pkg.sv]
// Shared types and constants of the overlap integral recursion block.
`default_nettype none
package oir_pkg;
	localparam int unsigned CW = 32;
	localparam int unsigned VW = 64;
	localparam int unsigned PW = 128;
	localparam int unsigned QW = 56;
	localparam int unsigned LW = 3;
	localparam logic signed [VW-1:0] ONE_Q40 = 64'sd1 <<< 40;
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	typedef logic signed [VW-1:0] val_t;
	typedef logic [PW-1:0] prod_t;
endpackage
`default_nettype wire

[rtl/core/oir_ram.sv]
// Generic single-port-write, registered-read memory.
`default_nettype none
module oir_ram #(
	parameter int W = 64,
	parameter int D = 192
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [0:D-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/core/overlap_integral_recursion.sv]
// Top level of the fixed-point Obara-Saika overlap recursion.
// Sequence: the reciprocal divider, then a table of its LMAX+1 multiples, then per axis a seed
// write and the computed entries, each summing its terms through the shared 32x32 multiplier
// (terms that do not apply are skipped) before it is written; then the results are emitted.
// Throughput: one request at a time; busy stays high until the final result transfer.
// Results cannot be stalled. Reset is asynchronous and returns the sequencer to idle.
`default_nettype none
module overlap_integral_recursion #(
	parameter int LMAX = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [31:0]   pa_x,
	input  wire logic signed [31:0]   pa_y,
	input  wire logic signed [31:0]   pa_z,
	input  wire logic signed [31:0]   pb_x,
	input  wire logic signed [31:0]   pb_y,
	input  wire logic signed [31:0]   pb_z,
	input  wire logic        [31:0]   gamma,
	input  wire logic        [2:0]    limit_a,
	input  wire logic        [2:0]    limit_b,
	output logic                      valid,
	output logic             [2:0]    row_i,
	output logic             [2:0]    col_j,
	output logic signed      [63:0]   overlap_x,
	output logic signed      [63:0]   overlap_y,
	output logic signed      [63:0]   overlap_z,
	output logic                      last
);
	localparam int IW = (LMAX < 2) ? 1 : $clog2(LMAX + 1);
	localparam int AW = 2 + 2 * IW;
	localparam int DEPTH = 3 << (2 * IW);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_KPP  = 4'd2;
	localparam logic [3:0] S_SEED = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_MAG  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_RND  = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_WR   = 4'd9;
	localparam logic [3:0] S_O0   = 4'd10;
	localparam logic [3:0] S_O1   = 4'd11;
	localparam logic [3:0] S_O2   = 4'd12;
	localparam logic [3:0] S_O3   = 4'd13;

	logic [3:0] state_q;
	logic signed [31:0] pa_q [0:2];
	logic signed [31:0] pb_q [0:2];
	logic [31:0] g_q;
	logic [IW-1:0] la_q, lb_q;
	logic [oir_pkg::QW-1:0] n_q;
	logic [32:0] rem_q;
	logic [5:0] dc_q;
	logic [63:0] kpp_q [0:LMAX];
	logic [63:0] ksum_q;
	logic [IW-1:0] kc_q;
	logic [1:0] ax_q;
	logic ph_q;
	logic [IW-1:0] si_q, sj_q;
	logic [1:0] t_q;
	logic [1:0] pc_q;
	logic [63:0] cm_q, em_q;
	logic neg_q;
	oir_pkg::prod_t prod_q;
	oir_pkg::val_t p_q, acc_q;
	logic [IW-1:0] oi_q, oj_q;
	logic valid_q, last_q;
	logic [2:0] row_q, col_q;
	oir_pkg::val_t ox_q, oy_q, oz_q;

	logic we, re;
	logic [AW-1:0] waddr, raddr;
	oir_pkg::val_t wdata, rdata;

	logic [32:0] rem_sh;
	logic geq;
	logic term_ok;
	logic [IW-1:0] kidx;
	logic [63:0] coef;
	logic [31:0] ma, mb;
	logic [63:0] pp64;
	oir_pkg::prod_t pp_sh;
	oir_pkg::prod_t rsum;
	logic [63:0] rm;
	logic rovf;
	oir_pkg::val_t psat;
	logic signed [64:0] ssum;
	oir_pkg::val_t sadd;
	logic [IW-1:0] la_in, lb_in;
	logic [IW-1:0] ti, tj;

	oir_ram #(.W(oir_pkg::VW), .D(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	assign la_in = (int'(limit_a) > LMAX) ? IW'(LMAX) : IW'(limit_a);
	assign lb_in = (int'(limit_b) > LMAX) ? IW'(LMAX) : IW'(limit_b);

	assign rem_sh = {rem_q[31:0], n_q[oir_pkg::QW-1]};
	assign geq = rem_sh >= {1'b0, g_q};

	assign term_ok = (t_q == 2'd0) || ((t_q == 2'd1) && (si_q != '0))
		|| ((t_q == 2'd2) && (sj_q != '0));
	assign kidx = (t_q == 2'd1) ? si_q : sj_q;
	assign ti = ph_q ? si_q + IW'(1) : '0;
	assign tj = ph_q ? sj_q : sj_q + IW'(1);

	always_comb begin
		if (t_q == 2'd0) begin
			coef = ph_q ? {{32{pa_q[ax_q][31]}}, pa_q[ax_q]} : {{32{pb_q[ax_q][31]}}, pb_q[ax_q]};
		end else begin
			coef = kpp_q[kidx];
		end
	end

	assign ma = pc_q[0] ? cm_q[63:32] : cm_q[31:0];
	assign mb = pc_q[1] ? em_q[63:32] : em_q[31:0];
	assign pp64 = ma * mb;

	always_comb begin
		case (2'(pc_q[0]) + 2'(pc_q[1]))
			2'd0:    pp_sh = {64'd0, pp64};
			2'd1:    pp_sh = {32'd0, pp64, 32'd0};
			default: pp_sh = {pp64, 64'd0};
		endcase
	end

	always_comb begin
		if (t_q == 2'd0) begin
			rsum = prod_q + (oir_pkg::prod_t'(1) << 23);
			rm = rsum[87:24];
			rovf = |rsum[127:88];
		end else begin
			rsum = prod_q + (oir_pkg::prod_t'(1) << 39);
			rm = rsum[103:40];
			rovf = |rsum[127:104];
		end
		if (!neg_q) begin
			psat = (rovf || rm[63]) ? oir_pkg::VMAX : oir_pkg::val_t'(rm);
		end else begin
			psat = (rovf || rm[63]) ? oir_pkg::VMIN : oir_pkg::val_t'(64'd0 - rm);
		end
	end

	assign ssum = {acc_q[63], acc_q} + {p_q[63], p_q};
	always_comb begin
		if (ssum[64] != ssum[63]) begin
			sadd = ssum[64] ? oir_pkg::VMIN : oir_pkg::VMAX;
		end else begin
			sadd = ssum[63:0];
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = {ax_q, ti, tj};
		wdata = acc_q;
		re = 1'b0;
		raddr = {ax_q, si_q, sj_q};
		case (state_q)
			S_SEED: begin
				we = 1'b1;
				waddr = {ax_q, {IW{1'b0}}, {IW{1'b0}}};
				wdata = oir_pkg::ONE_Q40;
			end
			S_WR: begin
				we = 1'b1;
			end
			S_RD: begin
				re = term_ok;
				if (t_q == 2'd1) begin
					raddr = {ax_q, si_q - IW'(1), sj_q};
				end else if (t_q == 2'd2) begin
					raddr = {ax_q, si_q, sj_q - IW'(1)};
				end
			end
			S_O0: begin
				re = 1'b1;
				raddr = {2'd0, oi_q, oj_q};
			end
			S_O1: begin
				re = 1'b1;
				raddr = {2'd1, oi_q, oj_q};
			end
			S_O2: begin
				re = 1'b1;
				raddr = {2'd2, oi_q, oj_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pa_q[0] <= pa_x;
				pa_q[1] <= pa_y;
				pa_q[2] <= pa_z;
				pb_q[0] <= pb_x;
				pb_q[1] <= pb_y;
				pb_q[2] <= pb_z;
				g_q <= (gamma == 32'd0) ? 32'd1 : gamma;
				la_q <= la_in;
				lb_q <= lb_in;
				n_q <= {1'b1, 24'd0, gamma[31:1]};
				rem_q <= '0;
				ksum_q <= '0;
			end
			S_DIV: begin
				rem_q <= geq ? rem_sh - {1'b0, g_q} : rem_sh;
				n_q <= {n_q[oir_pkg::QW-2:0], geq};
			end
			S_KPP: begin
				kpp_q[kc_q] <= ksum_q;
				ksum_q <= ksum_q + {8'd0, n_q};
			end
			S_MAG: begin
				cm_q <= coef[63] ? 64'd0 - coef : coef;
				em_q <= rdata[63] ? 64'd0 - rdata : rdata;
				neg_q <= coef[63] ^ rdata[63];
				prod_q <= '0;
			end
			S_MUL: begin
				prod_q <= prod_q + pp_sh;
			end
			S_RND: begin
				p_q <= psat;
			end
			S_ACC: begin
				acc_q <= (t_q == 2'd0) ? p_q : sadd;
			end
			S_O1: begin
				ox_q <= rdata;
			end
			S_O2: begin
				oy_q <= rdata;
			end
			S_O3: begin
				oz_q <= rdata;
				row_q <= 3'(oi_q);
				col_q <= 3'(oj_q);
				last_q <= (oi_q == la_q) && (oj_q == lb_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dc_q <= '0;
			kc_q <= '0;
			ax_q <= '0;
			ph_q <= 1'b0;
			si_q <= '0;
			sj_q <= '0;
			t_q <= '0;
			pc_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= (state_q == S_O3);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
						dc_q <= '0;
					end
				end
				S_DIV: begin
					dc_q <= dc_q + 6'd1;
					if (dc_q == 6'(oir_pkg::QW - 1)) begin
						state_q <= S_KPP;
						kc_q <= '0;
					end
				end
				S_KPP: begin
					kc_q <= kc_q + IW'(1);
					if (kc_q == IW'(LMAX)) begin
						state_q <= S_SEED;
						ax_q <= '0;
					end
				end
				S_SEED: begin
					si_q <= '0;
					sj_q <= '0;
					t_q <= '0;
					if (lb_q != '0) begin
						ph_q <= 1'b0;
						state_q <= S_RD;
					end else if (la_q != '0) begin
						ph_q <= 1'b1;
						state_q <= S_RD;
					end else if (ax_q == 2'd2) begin
						state_q <= S_O0;
						oi_q <= '0;
						oj_q <= '0;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				S_RD: begin
					if (t_q == 2'd3) begin
						state_q <= S_WR;
					end else if (term_ok) begin
						state_q <= S_MAG;
					end else begin
						t_q <= t_q + 2'd1;
					end
				end
				S_MAG: begin
					state_q <= S_MUL;
					pc_q <= '0;
				end
				S_MUL: begin
					pc_q <= pc_q + 2'd1;
					if (pc_q == 2'd3) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					t_q <= t_q + 2'd1;
					state_q <= S_RD;
				end
				S_WR: begin
					t_q <= '0;
					state_q <= S_RD;
					if (!ph_q && (sj_q + IW'(1) != lb_q)) begin
						sj_q <= sj_q + IW'(1);
					end else if (ph_q && (sj_q != lb_q)) begin
						sj_q <= sj_q + IW'(1);
					end else if (!ph_q && (la_q != '0)) begin
						ph_q <= 1'b1;
						si_q <= '0;
						sj_q <= '0;
					end else if (ph_q && (si_q + IW'(1) != la_q)) begin
						si_q <= si_q + IW'(1);
						sj_q <= '0;
					end else if (ax_q == 2'd2) begin
						state_q <= S_O0;
						oi_q <= '0;
						oj_q <= '0;
					end else begin
						ax_q <= ax_q + 2'd1;
						state_q <= S_SEED;
					end
				end
				S_O0: begin
					state_q <= S_O1;
				end
				S_O1: begin
					state_q <= S_O2;
				end
				S_O2: begin
					state_q <= S_O3;
				end
				S_O3: begin
					state_q <= S_O0;
					if (oj_q == lb_q) begin
						oj_q <= '0;
						if (oi_q == la_q) begin
							state_q <= S_IDLE;
						end else begin
							oi_q <= oi_q + IW'(1);
						end
					end else begin
						oj_q <= oj_q + IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign valid = valid_q;
	assign row_i = row_q;
	assign col_j = col_q;
	assign overlap_x = ox_q;
	assign overlap_y = oy_q;
	assign overlap_z = oz_q;
	assign last = valid_q & last_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("result strobe held for two cycles");
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DIV)) else $error("accepted request not started");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> !busy) else $error("final transfer while still busy");
	a_term_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (t_q == 2'd3)) else $error("entry written before all terms");
endmodule
`default_nettype wire
